// File: rtl/string_escape_decoder_core_macros.svh
// Assertion helpers for the RTL of the escape decoder core.
`ifndef STRING_ESCAPE_DECODER_CORE_MACROS_SVH
`define STRING_ESCAPE_DECODER_CORE_MACROS_SVH

`ifndef SYNTH

`define SED_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define SED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SED_ASSERT_SAME(lbl, clk, rst_n, ante, cons)

`define SED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/sed_pkg.sv
package sed_pkg;

    localparam int ResDepth = 4;
    localparam int PTR_W    = $clog2(ResDepth);
    localparam int CNT_W    = $clog2(ResDepth + 1);

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LB     = 8'h62;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LR     = 8'h72;
    localparam logic [7:0] CH_LT     = 8'h74;
    localparam logic [7:0] CH_LV     = 8'h76;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_UX     = 8'h58;
    localparam logic [7:0] CH_LU     = 8'h75;
    localparam logic [7:0] CH_UU     = 8'h55;

    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_FF  = 8'd12;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_HT  = 8'd9;
    localparam logic [7:0] CODE_VT  = 8'd11;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ESC  = 3'd1,
        PH_ZERO = 3'd2,
        PH_OCT1 = 3'd3,
        PH_OCT2 = 3'd4,
        PH_HEX1 = 3'd5,
        PH_HEX2 = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA  = 3'd0,
        ST_END   = 3'd1,
        ST_UNREC = 3'd2,
        ST_OCT   = 3'd3,
        ST_HEX   = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_res;

    function automatic logic is_oct(input logic [7:0] b);
        return b inside {[CH_0:CH_7]};
    endfunction

    // Returns the digit value in the low four bits and a valid flag on top.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b inside {[CH_0:CH_9]}) begin
            d = b - CH_0;
            return {1'b1, d[3:0]};
        end
        if (b inside {[CH_UA:CH_UF]}) begin
            d = b - CH_UA + 8'd10;
            return {1'b1, d[3:0]};
        end
        if (b inside {[CH_LA:CH_LF]}) begin
            d = b - CH_LA + 8'd10;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

    // Zero means the character is not a single-character escape.
    function automatic logic [7:0] simple_escape(input logic [7:0] b);
        logic [7:0] v;
        case (b)
            CH_SQUOTE: v = CH_SQUOTE;
            CH_DQUOTE: v = CH_DQUOTE;
            CH_BSLASH: v = CH_BSLASH;
            CH_LA:     v = CODE_BEL;
            CH_LB:     v = CODE_BS;
            CH_LF:     v = CODE_FF;
            CH_LN:     v = CODE_LF;
            CH_LR:     v = CODE_CR;
            CH_LT:     v = CODE_HT;
            CH_LV:     v = CODE_VT;
            default:   v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/string_escape_decoder_core.sv
// Decodes the escape sequences of a string literal that arrives one raw byte per
// transfer, closed by a transfer with s_axis_tlast high. Each result transfer
// carries a decoded byte and a status in m_axis_tuser (0 data, 1 end ok,
// 2 unrecognized escape, 3 malformed octal, 4 malformed hex); m_axis_tlast
// marks the final result caused by one input transfer. One input transfer is
// taken every cycle while the output keeps up; an item is registered, then
// decoded and written into a four-entry result queue once the queue has room
// for two results, and the output is driven from the queue head. The output
// port moves one result per cycle while m_axis_tready is high, so an item that
// yields two results (a deferred NUL after \0) takes two output transfers, and
// items that yield none (a backslash, digits inside an escape, bytes after an error) take none.
`include "string_escape_decoder_core_macros.svh"

module string_escape_decoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [2:0] status
    output logic       m_axis_tlast
);
    import sed_pkg::*;

    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_in_end;

    t_phase              r_phase;
    t_phase              n_phase;
    logic [7:0]          r_partial;
    logic [7:0]          n_partial;
    logic                r_err;
    logic                n_err;

    t_res                r_fifo [ResDepth];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;

    t_res                res0;
    t_res                res1;
    logic [1:0]          push_cnt;
    logic [1:0]          push;
    logic                pop;
    logic                room;
    logic                consume;
    logic [7:0]          digit;
    logic [4:0]          hex;
    logic [7:0]          esc_val;
    t_res                head;

    assign room          = r_count <= CNT_W'(ResDepth - 2);
    assign consume       = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || consume;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push          = consume ? push_cnt : 2'd0;

    assign head          = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = r_count != '0;
    assign m_axis_tdata  = head.data;
    assign m_axis_tuser  = head.status;
    assign m_axis_tlast  = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_end  <= s_axis_tlast;
        end
    end

    assign digit   = r_in_byte - CH_0;
    assign hex     = hex_digit(r_in_byte);
    assign esc_val = simple_escape(r_in_byte);

    always_comb begin
        n_phase   = r_phase;
        n_partial = r_partial;
        n_err     = r_err;
        res0      = '{data: 8'h00, status: ST_DATA, last: 1'b1};
        res1      = '{data: 8'h00, status: ST_END, last: 1'b1};
        push_cnt  = 2'd0;
        if (r_in_end) begin
            if (!r_err) begin
                push_cnt = 2'd1;
                case (r_phase)
                    PH_ESC:  res0.status = ST_UNREC;
                    PH_ZERO: begin
                        res0.last = 1'b0;
                        push_cnt  = 2'd2;
                    end
                    PH_OCT1, PH_OCT2: res0.status = ST_OCT;
                    PH_HEX1, PH_HEX2: res0.status = ST_HEX;
                    default: res0.status = ST_END;
                endcase
            end
            n_phase   = PH_IDLE;
            n_partial = 8'h00;
            n_err     = 1'b0;
        end else if (!r_err) begin
            case (r_phase)
                PH_ESC: begin
                    if (r_in_byte == CH_0) begin
                        n_partial = 8'h00;
                        n_phase   = PH_ZERO;
                    end else if (is_oct(r_in_byte)) begin
                        n_partial = digit;
                        n_phase   = PH_OCT1;
                    end else if (r_in_byte == CH_LX || r_in_byte == CH_UX
                                 || r_in_byte == CH_LU || r_in_byte == CH_UU) begin
                        n_partial = 8'h00;
                        n_phase   = PH_HEX1;
                    end else if (esc_val == 8'h00) begin
                        res0.status = ST_UNREC;
                        push_cnt    = 2'd1;
                    end else begin
                        res0.data = esc_val;
                        push_cnt  = 2'd1;
                        n_phase   = PH_IDLE;
                    end
                end
                PH_ZERO: begin
                    if (is_oct(r_in_byte)) begin
                        n_partial = digit;
                        n_phase   = PH_OCT2;
                    end else if (r_in_byte == CH_BSLASH) begin
                        push_cnt = 2'd1;
                        n_phase  = PH_ESC;
                    end else begin
                        res0.last   = 1'b0;
                        res1.data   = r_in_byte;
                        res1.status = ST_DATA;
                        push_cnt    = 2'd2;
                        n_phase     = PH_IDLE;
                    end
                end
                PH_OCT1: begin
                    if (is_oct(r_in_byte)) begin
                        n_partial = {r_partial[4:0], digit[2:0]};
                        n_phase   = PH_OCT2;
                    end else begin
                        res0.status = ST_OCT;
                        push_cnt    = 2'd1;
                    end
                end
                PH_OCT2: begin
                    push_cnt = 2'd1;
                    if (is_oct(r_in_byte)) begin
                        res0.data = {r_partial[4:0], digit[2:0]};
                        n_partial = 8'h00;
                        n_phase   = PH_IDLE;
                    end else begin
                        res0.status = ST_OCT;
                    end
                end
                PH_HEX1: begin
                    if (hex[4]) begin
                        n_partial = {4'h0, hex[3:0]};
                        n_phase   = PH_HEX2;
                    end else begin
                        res0.status = ST_HEX;
                        push_cnt    = 2'd1;
                    end
                end
                PH_HEX2: begin
                    push_cnt = 2'd1;
                    if (hex[4]) begin
                        res0.data = {r_partial[3:0], hex[3:0]};
                        n_partial = 8'h00;
                        n_phase   = PH_IDLE;
                    end else begin
                        res0.status = ST_HEX;
                    end
                end
                default: begin
                    if (r_in_byte == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        res0.data = r_in_byte;
                        push_cnt  = 2'd1;
                        n_phase   = PH_IDLE;
                    end
                end
            endcase
            if (push_cnt != 2'd0 && res0.status != ST_DATA) begin
                n_err     = 1'b1;
                n_phase   = PH_IDLE;
                n_partial = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_partial <= 8'h00;
            r_err     <= 1'b0;
        end else if (consume) begin
            r_phase   <= n_phase;
            r_partial <= n_partial;
            r_err     <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (push == 2'd2) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(push);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= r_count + CNT_W'(push) - CNT_W'(pop);
        end
    end

    `SED_ASSERT_SAME(a_queue_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(ResDepth))
    `SED_ASSERT_SAME(a_silent_after_error, i_clk, i_rst_n,
        consume && r_err && !r_in_end, push == 2'd0)
    `SED_ASSERT_SAME(a_pair_last_order, i_clk, i_rst_n,
        push == 2'd2, res1.last && !res0.last && res0.status == ST_DATA)
    `SED_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, consume && r_in_end,
        r_phase == PH_IDLE && !r_err && r_partial == 8'h00)

endmodule

// File: tb/sv/testbench.sv
module testbench;
    import sed_pkg::*;

    typedef struct packed {
        logic       fin;
        logic [7:0] code;
    } lit_item_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [2:0] m_axis_tuser;           // [2:0] status
    logic       m_axis_tlast;

    lit_item_t lit_q[$];
    t_res      decoded_q[$];
    t_res      step_out[$];

    t_phase     esc_phase = PH_IDLE;
    logic [7:0] esc_value = 8'h00;
    logic       esc_error = 1'b0;

    logic [7:0] simple_chars [10] = '{CH_SQUOTE, CH_DQUOTE, CH_BSLASH, CH_LA, CH_LB,
                                      CH_LF, CH_LN, CH_LR, CH_LT, CH_LV};
    logic [7:0] hex_prefixes [4] = '{CH_LX, CH_UX, CH_LU, CH_UU};

    int  error_count = 0;
    int  items_in = 0;
    int  literals_in = 0;
    int  results_checked = 0;
    int  error_results = 0;
    int  counted = 0;
    bit  in_taken = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    int  ready_mode = 0;
    int  mode_left = 0;
    int  ready_phase = 0;

    string_escape_decoder_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit is_octal_digit(input logic [7:0] b);
        return b >= CH_0 && b <= CH_7;
    endfunction

    // Top bit flags a valid hex digit, low four bits hold its value.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (b >= CH_0 && b <= CH_9) begin
            d = b - CH_0;
        end else if (b >= CH_UA && b <= CH_UF) begin
            d = b - CH_UA + 8'd10;
        end else if (b >= CH_LA && b <= CH_LF) begin
            d = b - CH_LA + 8'd10;
        end else begin
            return 5'd0;
        end
        return {1'b1, d[3:0]};
    endfunction

    function automatic logic [7:0] esc_code(input logic [7:0] b);
        case (b)
            CH_SQUOTE: return CH_SQUOTE;
            CH_DQUOTE: return CH_DQUOTE;
            CH_BSLASH: return CH_BSLASH;
            CH_LA:     return CODE_BEL;
            CH_LB:     return CODE_BS;
            CH_LF:     return CODE_FF;
            CH_LN:     return CODE_LF;
            CH_LR:     return CODE_CR;
            CH_LT:     return CODE_HT;
            CH_LV:     return CODE_VT;
            default:   return 8'h00;
        endcase
    endfunction

    function automatic bit is_hex_prefix(input logic [7:0] b);
        return b == CH_LX || b == CH_UX || b == CH_LU || b == CH_UU;
    endfunction

    function automatic void emit(input logic [7:0] d, input t_status s);
        t_res r;
        r.data = d;
        r.status = s;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void flag_error(input t_status s);
        esc_error = 1'b1;
        esc_phase = PH_IDLE;
        esc_value = 8'h00;
        emit(8'h00, s);
    endfunction

    function automatic void decode_item(input logic [7:0] b, input logic fin);
        t_res       r;
        logic [4:0] hv;
        logic [7:0] acc;
        step_out.delete();
        hv = hex_nibble(b);
        acc = {esc_value[4:0], 3'b000} + (b - CH_0);
        if (fin) begin
            if (!esc_error) begin
                case (esc_phase)
                    PH_ESC: emit(8'h00, ST_UNREC);
                    PH_ZERO: begin
                        emit(8'h00, ST_DATA);
                        emit(8'h00, ST_END);
                    end
                    PH_OCT1, PH_OCT2: emit(8'h00, ST_OCT);
                    PH_HEX1, PH_HEX2: emit(8'h00, ST_HEX);
                    default: emit(8'h00, ST_END);
                endcase
            end
            esc_phase = PH_IDLE;
            esc_value = 8'h00;
            esc_error = 1'b0;
        end else if (!esc_error) begin
            case (esc_phase)
                PH_ESC: begin
                    if (b == CH_0) begin
                        esc_value = 8'h00;
                        esc_phase = PH_ZERO;
                    end else if (is_octal_digit(b)) begin
                        esc_value = b - CH_0;
                        esc_phase = PH_OCT1;
                    end else if (is_hex_prefix(b)) begin
                        esc_value = 8'h00;
                        esc_phase = PH_HEX1;
                    end else if (esc_code(b) == 8'h00) begin
                        flag_error(ST_UNREC);
                    end else begin
                        esc_phase = PH_IDLE;
                        emit(esc_code(b), ST_DATA);
                    end
                end
                PH_ZERO: begin
                    if (is_octal_digit(b)) begin
                        esc_value = b - CH_0;
                        esc_phase = PH_OCT2;
                    end else begin
                        // The pending NUL goes out first, then the byte counts as plain input.
                        emit(8'h00, ST_DATA);
                        if (b == CH_BSLASH) begin
                            esc_phase = PH_ESC;
                        end else begin
                            esc_phase = PH_IDLE;
                            emit(b, ST_DATA);
                        end
                    end
                end
                PH_OCT1: begin
                    if (is_octal_digit(b)) begin
                        esc_value = acc;
                        esc_phase = PH_OCT2;
                    end else begin
                        flag_error(ST_OCT);
                    end
                end
                PH_OCT2: begin
                    if (is_octal_digit(b)) begin
                        esc_value = 8'h00;
                        esc_phase = PH_IDLE;
                        emit(acc, ST_DATA);
                    end else begin
                        flag_error(ST_OCT);
                    end
                end
                PH_HEX1: begin
                    if (hv[4]) begin
                        esc_value = {4'h0, hv[3:0]};
                        esc_phase = PH_HEX2;
                    end else begin
                        flag_error(ST_HEX);
                    end
                end
                PH_HEX2: begin
                    if (hv[4]) begin
                        emit({esc_value[3:0], hv[3:0]}, ST_DATA);
                        esc_value = 8'h00;
                        esc_phase = PH_IDLE;
                    end else begin
                        flag_error(ST_HEX);
                    end
                end
                default: begin
                    if (b == CH_BSLASH) begin
                        esc_phase = PH_ESC;
                    end else begin
                        esc_phase = PH_IDLE;
                        emit(b, ST_DATA);
                    end
                end
            endcase
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i]) begin
            decoded_q.push_back(step_out[i]);
        end
    endfunction

    task automatic add_item(input logic [7:0] code, input logic fin, input bit count_it);
        lit_item_t it;
        it.code = code;
        it.fin = fin;
        lit_q.push_back(it);
        if (count_it) begin
            counted++;
        end
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_0 + {4'h0, v};
        end
        return (($urandom_range(0, 1) == 0) ? CH_UA : CH_LA) + {4'h0, v} - 8'd10;
    endfunction

    function automatic logic [7:0] octal_char(input int lo);
        return CH_0 + 8'($urandom_range(lo, 7));
    endfunction

    task automatic gen_literal(input bit noise);
        int         ntok;
        int         kind;
        logic [7:0] c;
        ntok = $urandom_range(0, 12);
        if (noise) begin
            repeat (ntok + 4) begin
                c = ($urandom_range(0, 2) == 0) ? CH_BSLASH : 8'($urandom_range(0, 255));
                add_item(c, 1'b0, 1'b1);
            end
        end else begin
            repeat (ntok) begin
                kind = $urandom_range(0, 11);
                case (kind)
                    5, 6: begin
                        add_item(CH_BSLASH, 1'b0, 1'b1);
                        add_item(simple_chars[$urandom_range(0, 9)], 1'b0, 1'b1);
                    end
                    7: begin
                        add_item(CH_BSLASH, 1'b0, 1'b1);
                        repeat (3) add_item(octal_char(0), 1'b0, 1'b1);
                    end
                    8, 9: begin
                        add_item(CH_BSLASH, 1'b0, 1'b1);
                        add_item(hex_prefixes[$urandom_range(0, 3)], 1'b0, 1'b1);
                        repeat (2) add_item(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b1);
                    end
                    10: begin
                        add_item(CH_BSLASH, 1'b0, 1'b1);
                        add_item(CH_0, 1'b0, 1'b1);
                    end
                    default: begin
                        c = 8'($urandom_range(0, 255));
                        if (c == CH_BSLASH) begin
                            c = c ^ 8'h80;
                        end
                        add_item(c, 1'b0, 1'b1);
                    end
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                kind = $urandom_range(0, 3);
                add_item(CH_BSLASH, 1'b0, 1'b1);
                case (kind)
                    0: begin
                        do begin
                            c = 8'($urandom_range(0, 255));
                        end while (is_octal_digit(c) || is_hex_prefix(c) || esc_code(c) != 0);
                        add_item(c, 1'b0, 1'b1);
                    end
                    1: begin
                        c = octal_char(0);
                        add_item(c, 1'b0, 1'b1);
                        if (c == CH_0 || $urandom_range(0, 1) == 0) begin
                            add_item(octal_char(0), 1'b0, 1'b1);
                        end
                        do begin
                            c = 8'($urandom_range(0, 255));
                        end while (is_octal_digit(c));
                        add_item(c, 1'b0, 1'b1);
                    end
                    2: begin
                        add_item(hex_prefixes[$urandom_range(0, 3)], 1'b0, 1'b1);
                        if ($urandom_range(0, 1) == 0) begin
                            add_item(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b1);
                        end
                        do begin
                            c = 8'($urandom_range(0, 255));
                        end while (hex_nibble(c) != 5'd0);
                        add_item(c, 1'b0, 1'b1);
                    end
                    default: begin
                        // The literal ends inside an unfinished escape.
                        case ($urandom_range(0, 5))
                            1: add_item(CH_0, 1'b0, 1'b1);
                            2: add_item(octal_char(1), 1'b0, 1'b1);
                            3: begin
                                add_item(octal_char(0), 1'b0, 1'b1);
                                add_item(octal_char(0), 1'b0, 1'b1);
                            end
                            4: add_item(hex_prefixes[$urandom_range(0, 3)], 1'b0, 1'b1);
                            5: begin
                                add_item(hex_prefixes[$urandom_range(0, 3)], 1'b0, 1'b1);
                                add_item(hex_char(4'($urandom_range(0, 15))), 1'b0, 1'b1);
                            end
                            default: ;
                        endcase
                    end
                endcase
                if (kind != 3) begin
                    repeat ($urandom_range(0, 4)) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end
        end
        add_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    endtask

    task automatic wait_drained();
        while (lit_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Sender: bursts of transfers separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && !in_taken) begin
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (lit_q.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= lit_q[0].code;
                s_axis_tlast <= lit_q[0].fin;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                              : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: changes its stall pattern now and then, and holds off once for a long stretch.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            ready_phase++;
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!long_hold_done && results_checked >= 300) begin
                long_hold_done = 1'b1;
                hold_left = 200;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (ready_mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (ready_phase % 3 != 2);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            in_taken = s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                decode_item(s_axis_tdata, s_axis_tlast);
                void'(lit_q.pop_front());
                items_in++;
                if (s_axis_tlast) begin
                    literals_in++;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result data=%02h status=%0d last=%0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = decoded_q.pop_front();
                    results_checked++;
                    if (want.status >= ST_UNREC) begin
                        error_results++;
                    end
                    if (m_axis_tdata != want.data || m_axis_tuser != want.status
                            || m_axis_tlast != want.last) begin
                        error_count++;
                        $display("%0t: result mismatch: expected data=%02h status=%0d last=%0b,",
                                 $time, want.data, want.status, want.last,
                                 " got data=%02h status=%0d last=%0b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Pass-through extremes, a simple escape, the deferred NUL before a plain byte
        // and before another escape, octal wrap and mixed-case hex.
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b0, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_LN, 1'b0, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_0, 1'b0, 1'b0);
        add_item(CH_UA, 1'b0, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_0, 1'b0, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_LT, 1'b0, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_7, 1'b0, 1'b0);
        add_item(CH_7, 1'b0, 1'b0);
        add_item(CH_7, 1'b0, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_UX, 1'b0, 1'b0);
        add_item(CH_LF, 1'b0, 1'b0);
        add_item(CH_UF, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        // End right after a lone \0, then an unknown escape with a dropped byte after it.
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(CH_0, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        add_item(CH_BSLASH, 1'b0, 1'b0);
        add_item(8'h71, 1'b0, 1'b0);
        add_item(CH_UA, 1'b0, 1'b0);
        add_item(8'h00, 1'b1, 1'b0);
        wait_drained();

        for (int chunk = 1; chunk <= 3; chunk++) begin
            while (counted < chunk * 575) gen_literal($urandom_range(0, 9) == 0);
            wait_drained();
        end

        $display("Decoded %0d input transfers in %0d literals into %0d result transfers,",
                 items_in, literals_in, results_checked);
        $display("%0d of them escape errors; long output hold-off exercised: %0b.",
                 error_results, long_hold_done);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #1600000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: string_escape_decoder_core.f
+incdir+rtl
rtl/sed_pkg.sv
rtl/string_escape_decoder_core.sv
tb/sv/testbench.sv
